[hw/rtl/tefr_pkg.sv]
// shared types and constants of the triangle rasterizer
`default_nettype none
package tefr_pkg;

   localparam int OC_W  = 18;   // offset vertex coordinate
   localparam int YC_W  = 19;   // scan row and coordinate differences
   localparam int PRD_W = 38;   // edge products
   localparam int C_W   = 40;   // edge constant term, divider dividend
   localparam int DIV_D = 19;   // divider divisor
   localparam int B_W   = 42;   // span bounds
   localparam int PX_W  = 13;   // in-map pixel coordinate
   localparam int WC_W  = PX_W - 6;
   localparam int DCNT_W = 6;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;   // undefined, no effect

   localparam logic CSR_ORIGIN_X = 1'b0;
   localparam logic CSR_ORIGIN_Y = 1'b1;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_CLR, S_BOX, S_ROW, S_MUL, S_ADD, S_DIVS, S_DIVW,
      S_EDGE, S_SPAN, S_RD, S_WR, S_RDX, S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic box;
      logic row_init;
      logic mul;
      logic add;
      logic div_start;
      logic edge_apply;
      logic row_next;
      logic row_skip;
      logic set_clip;
      logic span_init;
      logic rd;
      logic wr;
      logic clr_step;
      logic rd_word;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic row_done;
      logic y_neg;
      logic y_high;
      logic clip;
      logic edge_last;
      logic d_zero;
      logic div_done;
      logic span_empty;
      logic span_vis;
      logic word_last;
      logic clr_last;
   } status_type;

   function automatic logic signed [OC_W-1:0] min3(input logic signed [OC_W-1:0] a,
         input logic signed [OC_W-1:0] b, input logic signed [OC_W-1:0] c);
      logic signed [OC_W-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic signed [OC_W-1:0] max3(input logic signed [OC_W-1:0] a,
         input logic signed [OC_W-1:0] b, input logic signed [OC_W-1:0] c);
      logic signed [OC_W-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/triangle_edge_function_rasterizer.sv]
// top level of the triangle edge-function rasterizer
`default_nettype none
// Fills triangles into a MAP_WIDTH x MAP_HEIGHT one-bit coverage bitmap held
// in a ram of 64-bit words, (MAP_WIDTH+63)/64 words per row. Opcode 0 clears
// the bitmap, 1 draws a triangle, 2 reads one word, 3 does nothing; every
// transfer in gives exactly one transfer out. One item is worked at a time.
// After reset the bitmap is swept to zero, one word a cycle, before the
// first item is taken; a clear takes the same sweep. A draw walks the rows
// of the bounding box; each row runs every triangle edge through a shared
// multiply stage and a serial divider (skipped when an edge is horizontal),
// then read-modify-writes the covered words one at a time. Rows above or
// below the bitmap are skipped once a dropped pixel has set clipped. A new
// item is taken while the previous result still waits on rsp_stall.
module triangle_edge_function_rasterizer #(
   parameter int MAP_WIDTH  = 256,
   parameter int MAP_HEIGHT = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration writes
   input  wire logic               csr_write,
   input  wire logic               csr_index,
   input  wire logic signed [15:0] csr_wdata,
   // item transfer in
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic        [1:0]  req_opcode,
   input  wire logic signed [15:0] req_ax,
   input  wire logic signed [15:0] req_ay,
   input  wire logic signed [15:0] req_bx,
   input  wire logic signed [15:0] req_by_coord,
   input  wire logic signed [15:0] req_cx,
   input  wire logic signed [15:0] req_cy,
   input  wire logic        [9:0]  req_word_index,
   // result transfer out
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic             [63:0] rsp_read_data,
   output logic                    rsp_clipped
);
   import tefr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   tefr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .status     (status)
   );

   // edge math, span bounds and the bitmap itself
   tefr_dp #(
      .MAP_WIDTH  (MAP_WIDTH),
      .MAP_HEIGHT (MAP_HEIGHT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_opcode     (req_opcode),
      .req_ax         (req_ax),
      .req_ay         (req_ay),
      .req_bx         (req_bx),
      .req_by_coord   (req_by_coord),
      .req_cx         (req_cx),
      .req_cy         (req_cy),
      .req_word_index (req_word_index),
      .rsp_read_data  (rsp_read_data),
      .rsp_clipped    (rsp_clipped)
   );
endmodule
`default_nettype wire

[hw/rtl/tefr_ram.sv]
// generic single-write, single-read ram with registered read
`default_nettype none
module tefr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                 wdata,
   input  wire logic                             re,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic      [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

[hw/rtl/tefr_div.sv]
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module tefr_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [tefr_pkg::C_W-1:0]    dividend,
   input  wire logic [tefr_pkg::DIV_D-1:0]  divisor,
   output logic                             done,
   output logic      [tefr_pkg::C_W-1:0]    quotient,
   output logic      [tefr_pkg::DIV_D-1:0]  remainder
);
   import tefr_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [C_W-1:0]    n_ff, n_in;
   logic [DIV_D-1:0]  r_ff, r_in;
   logic [DIV_D-1:0]  d_ff, d_in;
   logic [DIV_D:0]    rs;
   logic              ge;

   always_comb begin
      rs      = {r_ff, n_ff[C_W-1]};
      ge      = rs >= {1'b0, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         r_in   = ge ? DIV_D'(rs - {1'b0, d_ff}) : DIV_D'(rs);
         n_in   = {n_ff[C_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(C_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      n_ff <= n_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done      = done_ff;
   assign quotient  = n_ff;
   assign remainder = r_ff;
endmodule
`default_nettype wire

[hw/rtl/tefr_dp.sv]
// rasterizer datapath: vertices, edge math, span bounds, bitmap store
`default_nettype none
module tefr_dp #(
   parameter int MAP_WIDTH  = 256,
   parameter int MAP_HEIGHT = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tefr_pkg::cmd_type    cmd,
   output tefr_pkg::status_type      status,
   input  wire logic                 csr_write,
   input  wire logic                 csr_index,
   input  wire logic signed [15:0]   csr_wdata,
   input  wire logic        [1:0]    req_opcode,
   input  wire logic signed [15:0]   req_ax,
   input  wire logic signed [15:0]   req_ay,
   input  wire logic signed [15:0]   req_bx,
   input  wire logic signed [15:0]   req_by_coord,
   input  wire logic signed [15:0]   req_cx,
   input  wire logic signed [15:0]   req_cy,
   input  wire logic        [9:0]    req_word_index,
   output logic             [63:0]   rsp_read_data,
   output logic                      rsp_clipped
);
   import tefr_pkg::*;

   localparam int WPR   = (MAP_WIDTH + 63) / 64;
   localparam int WORDS = WPR * MAP_HEIGHT;
   localparam int AW    = $clog2(WORDS > 1 ? WORDS : 2);

   logic signed [15:0]     org_x_ff, org_y_ff;
   logic        [1:0]      op_ff;
   logic        [9:0]      widx_ff;
   logic signed [OC_W-1:0] vx_ff [3];
   logic signed [OC_W-1:0] vy_ff [3];
   logic signed [OC_W-1:0] minx_ff, maxx_ff, maxy_ff;
   logic signed [YC_W-1:0] y_ff;
   logic signed [B_W-1:0]  lo_ff, hi_ff;
   logic        [1:0]      edge_ff;
   logic signed [PRD_W-1:0] p1_ff, p2_ff;
   logic signed [YC_W-1:0] d_ff;
   logic signed [C_W-1:0]  c_ff;
   logic                   clip_ff;
   logic        [PX_W-1:0] lox_ff, hix_ff;
   logic        [WC_W-1:0] wi_ff;
   logic        [AW-1:0]   clr_ff;
   logic        [63:0]     rdata_out_ff;
   logic                   clip_out_ff;

   logic signed [YC_W-1:0] dx, dy, dd;
   logic        [C_W-1:0]  c_mag;
   logic        [DIV_D-1:0] d_mag;
   logic                   div_done;
   logic        [C_W-1:0]  quo;
   logic        [DIV_D-1:0] rem;
   logic signed [B_W-1:0]  mag, fd;
   logic signed [B_W-1:0]  lo_c, hi_c;
   logic                   span_clip;
   logic        [AW-1:0]   row_addr, waddr, raddr;
   logic        [63:0]     ram_rdata, wdata, mask;
   logic        [5:0]      lo_b, hi_b;
   logic                   ram_we, ram_re, read_oob;

   // edge terms for vertex pair (0,1); vertices rotate after each edge
   assign dx = YC_W'(vx_ff[0]) - YC_W'(vx_ff[1]);
   assign dd = YC_W'(vy_ff[0]) - YC_W'(vy_ff[1]);
   assign dy = y_ff - YC_W'(vy_ff[0]);

   assign c_mag = c_ff[C_W-1] ? C_W'(-c_ff) : C_W'(c_ff);
   assign d_mag = d_ff[YC_W-1] ? DIV_D'(-d_ff) : DIV_D'(d_ff);

   tefr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (c_mag),
      .divisor   (d_mag),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   // floor(c / |d|)
   assign mag = B_W'(quo) + B_W'(c_ff[C_W-1] && (rem != '0));
   assign fd  = c_ff[C_W-1] ? -mag : mag;

   assign span_clip = (lo_ff < 0) || (hi_ff >= B_W'(MAP_WIDTH));
   assign lo_c = (lo_ff < 0) ? '0 : lo_ff;
   assign hi_c = (hi_ff >= B_W'(MAP_WIDTH)) ? B_W'(MAP_WIDTH - 1) : hi_ff;

   assign row_addr = AW'(32'(y_ff[PX_W-1:0]) * 32'(WPR) + 32'(wi_ff));
   assign lo_b = (wi_ff == lox_ff[PX_W-1:6]) ? lox_ff[5:0] : 6'd0;
   assign hi_b = (wi_ff == hix_ff[PX_W-1:6]) ? hix_ff[5:0] : 6'd63;
   assign mask = ({64{1'b1}} << lo_b) & ({64{1'b1}} >> (6'd63 - hi_b));

   assign ram_we = cmd.wr || cmd.clr_step;
   assign ram_re = cmd.rd || cmd.rd_word;
   assign waddr  = cmd.clr_step ? clr_ff : row_addr;
   assign wdata  = cmd.clr_step ? '0 : (ram_rdata | mask);
   assign raddr  = cmd.rd_word ? AW'(widx_ff) : row_addr;
   assign read_oob = 32'(widx_ff) >= 32'(WORDS);

   tefr_ram #(.WIDTH(64), .DEPTH(WORDS)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (ram_re),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      status.row_done   = y_ff >= YC_W'(maxy_ff);
      status.y_neg      = y_ff < 0;
      status.y_high     = y_ff >= YC_W'(MAP_HEIGHT);
      status.clip       = clip_ff;
      status.edge_last  = edge_ff == 2'd2;
      status.d_zero     = d_ff == '0;
      status.div_done   = div_done;
      status.span_empty = lo_ff > hi_ff;
      status.span_vis   = lo_c <= hi_c;
      status.word_last  = wi_ff == hix_ff[PX_W-1:6];
      status.clr_last   = clr_ff == AW'(WORDS - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
         clr_ff   <= '0;
      end else begin
         if (csr_write && csr_index == CSR_ORIGIN_X) begin
            org_x_ff <= csr_wdata;
         end
         if (csr_write && csr_index == CSR_ORIGIN_Y) begin
            org_y_ff <= csr_wdata;
         end
         if (cmd.clr_step) begin
            clr_ff <= status.clr_last ? '0 : clr_ff + 1'b1;
         end
      end

      if (cmd.load) begin
         op_ff    <= req_opcode;
         widx_ff  <= req_word_index;
         vx_ff[0] <= OC_W'(req_ax) - OC_W'(org_x_ff);
         vy_ff[0] <= OC_W'(req_ay) - OC_W'(org_y_ff);
         vx_ff[1] <= OC_W'(req_bx) - OC_W'(org_x_ff);
         vy_ff[1] <= OC_W'(req_by_coord) - OC_W'(org_y_ff);
         vx_ff[2] <= OC_W'(req_cx) - OC_W'(org_x_ff);
         vy_ff[2] <= OC_W'(req_cy) - OC_W'(org_y_ff);
      end
      if (cmd.box) begin
         minx_ff <= min3(vx_ff[0], vx_ff[1], vx_ff[2]);
         maxx_ff <= max3(vx_ff[0], vx_ff[1], vx_ff[2]);
         maxy_ff <= max3(vy_ff[0], vy_ff[1], vy_ff[2]);
         y_ff    <= YC_W'(min3(vy_ff[0], vy_ff[1], vy_ff[2]));
         clip_ff <= 1'b0;
      end
      if (cmd.row_init) begin
         lo_ff   <= B_W'(minx_ff);
         hi_ff   <= B_W'(maxx_ff) - 1'b1;
         edge_ff <= '0;
      end
      if (cmd.mul) begin
         p1_ff <= PRD_W'(dx) * PRD_W'(dy);
         p2_ff <= PRD_W'(dd) * PRD_W'(vx_ff[0]);
         d_ff  <= dd;
      end
      if (cmd.add) begin
         c_ff <= C_W'(p1_ff) + C_W'(p2_ff);
      end
      if (cmd.edge_apply) begin
         if (d_ff == '0) begin
            if (c_ff < 0) begin
               lo_ff <= B_W'(1);
               hi_ff <= '0;
            end
         end else if (!d_ff[YC_W-1]) begin
            if (fd < hi_ff) begin
               hi_ff <= fd;
            end
         end else begin
            if (-fd > lo_ff) begin
               lo_ff <= -fd;
            end
         end
         edge_ff  <= edge_ff + 1'b1;
         vx_ff[0] <= vx_ff[1];
         vx_ff[1] <= vx_ff[2];
         vx_ff[2] <= vx_ff[0];
         vy_ff[0] <= vy_ff[1];
         vy_ff[1] <= vy_ff[2];
         vy_ff[2] <= vy_ff[0];
      end
      if (cmd.row_next) begin
         y_ff <= y_ff + 1'b1;
      end
      if (cmd.row_skip) begin
         y_ff <= '0;
      end
      if (cmd.set_clip || (cmd.span_init && span_clip)) begin
         clip_ff <= 1'b1;
      end
      if (cmd.span_init) begin
         lox_ff <= PX_W'(lo_c);
         hix_ff <= PX_W'(hi_c);
         wi_ff  <= lo_c[PX_W-1:6];
      end
      if (cmd.wr) begin
         wi_ff <= wi_ff + 1'b1;
      end
      if (cmd.result_load) begin
         rdata_out_ff <= (op_ff == OP_READ && !read_oob) ? ram_rdata : '0;
         clip_out_ff  <= (op_ff == OP_DRAW) && clip_ff;
      end
   end

   assign rsp_read_data = rdata_out_ff;
   assign rsp_clipped   = clip_out_ff;
endmodule
`default_nettype wire

[hw/rtl/tefr_ctrl.sv]
// rasterizer controller: sequencing and handshakes
`default_nettype none
module tefr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_opcode,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output tefr_pkg::cmd_type          cmd,
   input  wire tefr_pkg::status_type  status
);
   import tefr_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (req_opcode)
                  OP_CLEAR: state_in = S_CLR;
                  OP_DRAW:  state_in = S_BOX;
                  OP_READ:  state_in = S_RDX;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_DONE;
            end
         end
         S_BOX: begin
            cmd.box  = 1'b1;
            state_in = S_ROW;
         end
         S_ROW: begin
            if (status.row_done) begin
               state_in = S_DONE;
            end else if (status.y_neg && status.clip) begin
               cmd.row_skip = 1'b1;
            end else if (status.y_high && status.clip) begin
               state_in = S_DONE;
            end else begin
               cmd.row_init = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_DIVS;
         end
         S_DIVS: begin
            if (status.d_zero) begin
               state_in = S_EDGE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVW;
            end
         end
         S_DIVW: begin
            if (status.div_done) begin
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            cmd.edge_apply = 1'b1;
            state_in = status.edge_last ? S_SPAN : S_MUL;
         end
         S_SPAN: begin
            if (status.span_empty) begin
               cmd.row_next = 1'b1;
               state_in     = S_ROW;
            end else if (status.y_neg || status.y_high) begin
               cmd.set_clip = 1'b1;
               cmd.row_next = 1'b1;
               state_in     = S_ROW;
            end else begin
               cmd.span_init = 1'b1;
               if (status.span_vis) begin
                  state_in = S_RD;
               end else begin
                  cmd.row_next = 1'b1;
                  state_in     = S_ROW;
               end
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_WR;
         end
         S_WR: begin
            cmd.wr = 1'b1;
            if (status.word_last) begin
               cmd.row_next = 1'b1;
               state_in     = S_ROW;
            end else begin
               state_in = S_RD;
            end
         end
         S_RDX: begin
            cmd.rd_word = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/tefr_checker.sv]
// port-level checks of the rasterizer, bound to the top level
`default_nettype none
module tefr_port_checks (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [63:0] rsp_read_data,
   input wire logic        rsp_clipped
);
   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_clipped))
      else $error("result changed while stalled");

   // one item at a time: busy right after a transfer in
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

   // read data and clipped come from different opcodes
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_data != '0) |-> !rsp_clipped)
      else $error("read data and clipped both set");

   // reset empties the result side
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind triangle_edge_function_rasterizer tefr_port_checks u_tefr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_read_data (rsp_read_data),
   .rsp_clipped   (rsp_clipped)
);
`default_nettype wire
